// File: src/assert_macros.svh
// Assertion macros used by the encoder datapath.
// Concurrent checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define BRLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Expression must never be true outside reset
`define BRLE_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define BRLE_ASSERT(lbl, clk, rstn, prop, msg)
`define BRLE_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: src/brle_pkg.sv
// Package for the byte run-length encoder: widths, constants, shared types.
// No dependencies.
package brle_pkg;

  localparam int unsigned MAX_PACKET_DEF     = 128;
  localparam int unsigned BYTES_PER_WORD_DEF = 8;

  localparam int unsigned CNT_W   = 8;   // packet byte count, up to 128
  localparam int unsigned REP_W   = 7;
  localparam int unsigned PCNT_W  = 4;   // bytes in a word
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned TOTAL_W = 24;
  localparam int unsigned OLEN_W  = 9;   // encoded bytes of one item

  localparam logic [7:0]         HDR_RUN   = 8'h80;
  localparam logic [REP_W-1:0]   REP_MAX   = 7'd127;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DISP    = 6'b000010,
    ST_S1_HDR  = 6'b000100,
    ST_S1_BODY = 6'b001000,
    ST_S2_HDR  = 6'b010000,
    ST_S2_BODY = 6'b100000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // input beat taken
    logic byte_valid;  // an encoded byte is offered to the packer
    logic src_body;    // 0: header byte, 1: body byte
    logic seg2;        // second packet of this item
    logic final_byte;  // last encoded byte of this item
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic s1_v;
    logic s2_v;
    logic body_last;
    logic take;        // packer took the offered byte
  } dp_stat_t;

endpackage

// File: src/brle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/brle_ctrl.sv
// Sequencer for the encoder: walks header and body of up to two packets per beat.
// Depends on brle_pkg.
module brle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  brle_pkg::dp_stat_t  stat_i,
  output brle_pkg::ctrl_cmd_t cmd_o
);
  import brle_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.accept     = in_valid_i && (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) state_d = ST_DISP;
      end
      ST_DISP: begin
        if (stat_i.s1_v)      state_d = ST_S1_HDR;
        else if (stat_i.s2_v) state_d = ST_S2_HDR;
        else                  state_d = ST_IDLE;
      end
      ST_S1_HDR: begin
        cmd_o.byte_valid = 1'b1;
        if (stat_i.take) state_d = ST_S1_BODY;
      end
      ST_S1_BODY: begin
        cmd_o.byte_valid = 1'b1;
        cmd_o.src_body   = 1'b1;
        cmd_o.final_byte = stat_i.body_last && !stat_i.s2_v;
        if (stat_i.take && stat_i.body_last) begin
          state_d = stat_i.s2_v ? ST_S2_HDR : ST_IDLE;
        end
      end
      ST_S2_HDR: begin
        cmd_o.byte_valid = 1'b1;
        cmd_o.seg2       = 1'b1;
        if (stat_i.take) state_d = ST_S2_BODY;
      end
      ST_S2_BODY: begin
        cmd_o.byte_valid = 1'b1;
        cmd_o.src_body   = 1'b1;
        cmd_o.seg2       = 1'b1;
        cmd_o.final_byte = stat_i.body_last;
        if (stat_i.take && stat_i.body_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: src/brle_dp.sv
// Datapath for the encoder: packet state, literal store, byte packer, output register.
// Depends on brle_pkg, brle_ram and assert_macros.svh.
`include "assert_macros.svh"
module brle_dp #(
  parameter int unsigned MAX_PACKET     = brle_pkg::MAX_PACKET_DEF,
  parameter int unsigned BYTES_PER_WORD = brle_pkg::BYTES_PER_WORD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_in_i,
  input  brle_pkg::ctrl_cmd_t           cmd_i,
  output brle_pkg::dp_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [brle_pkg::WORD_W-1:0]   out_word_o,
  output logic [brle_pkg::PCNT_W-1:0]   byte_count_o,
  output logic                          last_result_o,
  output logic [brle_pkg::TOTAL_W-1:0]  encoded_total_o
);
  import brle_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PACKET);
  localparam logic [CNT_W-1:0]  MAXC    = CNT_W'(MAX_PACKET);
  localparam logic [PCNT_W-1:0] BPW_M1  = PCNT_W'(BYTES_PER_WORD - 1);

  // packet state
  logic [CNT_W-1:0]   pend_q, pend_d;
  logic [REP_W-1:0]   rep_q, rep_d;
  logic [7:0]         cmp_q, cmp_d;
  logic [TOTAL_W-1:0] enc_q, enc_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  // packet descriptors of the item in flight
  logic             s1v_q, s1run_q, s2v_q, s2run_q;
  logic [CNT_W-1:0] s1len_q, s2len_q;
  logic [7:0]       s1byte_q, s2byte_q;
  logic             s1v_d, s1run_d, s2v_d, s2run_d;
  logic [CNT_W-1:0] s1len_d, s2len_d;
  logic [7:0]       s1byte_d, s2byte_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [OLEN_W-1:0]  olen;
  logic [TOTAL_W:0]   sum;
  logic [CNT_W-1:0]   pend_mid;
  logic [REP_W-1:0]   rep_mid;

  // decide packets on an accepted beat
  always_comb begin
    cmp_d    = cmp_q;
    rep_mid  = rep_q;
    pend_mid = pend_q;
    s1v_d    = 1'b0;
    s1run_d  = 1'b0;
    s1len_d  = '0;
    s1byte_d = cmp_q;
    we       = 1'b0;
    waddr    = '0;
    if (pend_q == '0) begin
      we       = 1'b1;
      cmp_d    = data_byte_i;
      rep_mid  = '0;
      pend_mid = CNT_W'(1);
    end else if (data_byte_i == cmp_q) begin
      rep_mid = (rep_q < REP_MAX) ? rep_q + REP_W'(1) : rep_q;
      if (rep_mid == REP_W'(2) && pend_q > CNT_W'(2)) begin
        // run start: the bytes before the run go out as a literal packet
        s1v_d    = 1'b1;
        s1len_d  = pend_q - CNT_W'(2);
        pend_mid = CNT_W'(3);
      end else begin
        we       = 1'b1;
        waddr    = pend_q[AW-1:0];
        pend_mid = pend_q + CNT_W'(1);
      end
    end else if (rep_q >= REP_W'(2)) begin
      // run end: send the run, this byte opens a new packet
      s1v_d    = 1'b1;
      s1run_d  = 1'b1;
      s1len_d  = pend_q;
      we       = 1'b1;
      cmp_d    = data_byte_i;
      rep_mid  = '0;
      pend_mid = CNT_W'(1);
    end else begin
      we       = 1'b1;
      waddr    = pend_q[AW-1:0];
      cmp_d    = data_byte_i;
      rep_mid  = '0;
      pend_mid = pend_q + CNT_W'(1);
    end
    // packet full or frame end
    s2v_d    = (pend_mid >= MAXC) || last_in_i;
    s2run_d  = (rep_mid >= REP_W'(2));
    s2len_d  = pend_mid;
    s2byte_d = cmp_d;
    pend_d   = s2v_d ? '0 : pend_mid;
    rep_d    = s2v_d ? '0 : rep_mid;

    olen = '0;
    if (s1v_d) olen = s1run_d ? OLEN_W'(2) : OLEN_W'(s1len_d) + OLEN_W'(1);
    if (s2v_d) olen = olen + (s2run_d ? OLEN_W'(2) : OLEN_W'(s2len_d) + OLEN_W'(1));
    sum   = {1'b0, enc_q} + (TOTAL_W + 1)'(olen);
    enc_d = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    total_d = last_in_i ? enc_d : '0;
    if (last_in_i) enc_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      rep_q  <= '0;
      cmp_q  <= '0;
      enc_q  <= '0;
      s1v_q  <= 1'b0;
      s2v_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      pend_q <= pend_d;
      rep_q  <= rep_d;
      cmp_q  <= cmp_d;
      enc_q  <= enc_d;
      s1v_q  <= s1v_d;
      s2v_q  <= s2v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1run_q  <= s1run_d;
      s1len_q  <= s1len_d;
      s1byte_q <= s1byte_d;
      s2run_q  <= s2run_d;
      s2len_q  <= s2len_d;
      s2byte_q <= s2byte_d;
      total_q  <= total_d;
    end
  end

  // current packet and byte selection
  logic             cur_run;
  logic [CNT_W-1:0] cur_len;
  logic [7:0]       cur_byte, rdata, byte_val;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [AW-1:0]    raddr;
  logic             take, complete, can_emit, hdr_take;

  assign cur_run  = cmd_i.seg2 ? s2run_q  : s1run_q;
  assign cur_len  = cmd_i.seg2 ? s2len_q  : s1len_q;
  assign cur_byte = cmd_i.seg2 ? s2byte_q : s1byte_q;

  always_comb begin
    if (!cmd_i.src_body) begin
      byte_val = {cur_run, 7'(cur_len - CNT_W'(1))} | (cur_run ? HDR_RUN : 8'h00);
    end else begin
      byte_val = cur_run ? cur_byte : rdata;
    end
  end

  // packer: lane fill, word completes when full or at item end
  logic [WORD_W-1:0] word_q, word_merged;
  logic [PCNT_W-1:0] pcnt_q;

  always_comb begin
    word_merged = word_q;
    for (int j = 0; j < BYTES_PER_WORD; j++) begin
      if (pcnt_q == PCNT_W'(j)) word_merged[8*j +: 8] = byte_val;
    end
  end

  assign can_emit = !out_valid_o || !out_stall_i;
  assign complete = (pcnt_q == BPW_M1) || cmd_i.final_byte;
  assign take     = cmd_i.byte_valid && (!complete || can_emit);
  assign hdr_take = take && !cmd_i.src_body;
  assign idx_d    = hdr_take ? '0 : idx_q + CNT_W'(1);
  assign raddr    = hdr_take ? '0 : idx_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      // a new word replaces the one leaving; otherwise a taken word clears valid
      if (take && complete) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (take) begin
        pcnt_q <= complete ? '0 : pcnt_q + PCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q  <= idx_d;
      word_q <= complete ? '0 : word_merged;
      if (complete) begin
        out_word_o      <= word_merged;
        byte_count_o    <= pcnt_q + PCNT_W'(1);
        last_result_o   <= cmd_i.final_byte;
        encoded_total_o <= cmd_i.final_byte ? total_q : '0;
      end
    end else if (cmd_i.accept) begin
      word_q <= '0;
    end
  end

  brle_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PACKET)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && we),
    .waddr_i(waddr),
    .wdata_i(data_byte_i),
    .re_i   (take),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign stat_o.s1_v      = s1v_q;
  assign stat_o.s2_v      = s2v_q;
  assign stat_o.body_last = cur_run || (idx_q == cur_len - CNT_W'(1));
  assign stat_o.take      = take;

  `BRLE_ASSERT(a_pend_range, clk_i, rst_ni, pend_q < MAXC, "open packet reached full size")
  `BRLE_ASSERT(a_pcnt_range, clk_i, rst_ni, pcnt_q <= BPW_M1, "packer lane count out of range")
  `BRLE_ASSERT(a_final_flush, clk_i, rst_ni, take && cmd_i.final_byte |=> pcnt_q == '0 && out_valid_o, "item end did not flush the packer")

endmodule

// File: src/byte_run_length_encoder.sv
// Top level of the byte run-length encoder: sequencer plus datapath.
// Depends on brle_pkg, brle_ctrl, brle_dp.
//
//  channel | direction | handshake             | payload
//  input   | in        | in_valid_i/in_stall_o | data_byte_i, last_in_i
//  output  | out       | out_valid_o/out_stall_i | out_word_o, byte_count_o,
//          |           |                       | last_result_o, encoded_total_o
//
// An input beat is accepted in the idle state and dispatched; for each packet it
// closes, the sequencer offers header and body one byte a cycle to the packer,
// reading literal bytes from the store RAM, while no output stall holds the packer.
// Output stall holds the packer only when a word is complete and the output
// register is still occupied. Reset clears all control state; the store needs none.
module byte_run_length_encoder #(
  parameter int unsigned MAX_PACKET     = brle_pkg::MAX_PACKET_DEF,
  parameter int unsigned BYTES_PER_WORD = brle_pkg::BYTES_PER_WORD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [brle_pkg::WORD_W-1:0]   out_word_o,
  output logic [brle_pkg::PCNT_W-1:0]   byte_count_o,
  output logic                          last_result_o,
  output logic [brle_pkg::TOTAL_W-1:0]  encoded_total_o
);
  import brle_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  brle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  brle_dp #(
    .MAX_PACKET    (MAX_PACKET),
    .BYTES_PER_WORD(BYTES_PER_WORD)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .last_in_i      (last_in_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_word_o     (out_word_o),
    .byte_count_o   (byte_count_o),
    .last_result_o  (last_result_o),
    .encoded_total_o(encoded_total_o)
  );

endmodule
